// ===== rtl/core/bid_pkg.sv =====
// Package for the bytecode instruction delimiter: opcode constants, status codes,
// decoder phase codes, the result record and the opcode length table.
// No dependencies.
package bid_pkg;

    localparam int OFFSET_BITS_DEF = 16;

    localparam logic [7:0] OP_TABLESWITCH  = 8'haa;
    localparam logic [7:0] OP_LOOKUPSWITCH = 8'hab;
    localparam logic [7:0] OP_WIDE         = 8'hc4;
    localparam logic [7:0] OP_IINC         = 8'h84;

    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_TRUNC_TSW   = 4'd1;
    localparam logic [3:0] ST_BAD_BOUNDS  = 4'd2;
    localparam logic [3:0] ST_TRUNC_ENTRY = 4'd3;
    localparam logic [3:0] ST_TRUNC_LSW   = 4'd4;
    localparam logic [3:0] ST_BAD_PAIRS   = 4'd5;
    localparam logic [3:0] ST_TRUNC_WIDE  = 4'd6;
    localparam logic [3:0] ST_BAD_WIDE_OP = 4'd7;
    localparam logic [3:0] ST_OVERRUN     = 4'd8;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_PLAIN  = 3'd1;
    localparam logic [2:0] PH_WIDE   = 3'd2;
    localparam logic [2:0] PH_SKIP   = 3'd3;
    localparam logic [2:0] PH_FIELD1 = 3'd4;
    localparam logic [2:0] PH_FIELD2 = 3'd5;
    localparam logic [2:0] PH_BODY   = 3'd6;

    typedef struct packed {
        logic       valid;
        logic [7:0] code_byte;
    } bid_in_t;

    typedef struct packed {
        logic [15:0] start_offset;
        logic [15:0] instr_length;
        logic [7:0]  opcode_seen;
        logic [15:0] instr_count;
        logic [3:0]  status;
        logic        done_res;
    } bid_result_t;

    // Length in bytes of every opcode outside the switch and wide forms.
    function automatic logic [2:0] fixed_len(input logic [7:0] op);
        logic [2:0] len;
        case (op) inside
            8'h10, 8'h12, [8'h15:8'h19], [8'h36:8'h3a], 8'ha9, 8'hbc:
                len = 3'd2;
            8'h11, 8'h13, 8'h14, [8'h99:8'ha8], 8'hc6, 8'hc7, [8'hb2:8'hb8],
            8'hbb, 8'hbd, 8'hc0, 8'hc1, 8'h84:
                len = 3'd3;
            8'hb9, 8'hba, 8'hc8, 8'hc9:
                len = 3'd5;
            8'hc5:
                len = 3'd4;
            default:
                len = 3'd1;
        endcase
        return len;
    endfunction

    // Opcodes that may follow the wide prefix with a 16-bit index.
    function automatic logic is_wide_target(input logic [7:0] op);
        logic hit;
        case (op) inside
            [8'h15:8'h19], [8'h36:8'h3a], 8'ha9: hit = 1'b1;
            default:                             hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

// ===== rtl/core/bid_in_stage.sv =====
// Input register of the bytecode instruction delimiter.
// Depends on bid_pkg.
module bid_in_stage
    import bid_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_code_byte,
    input  logic       fire,
    output bid_in_t    q
);

    logic       valid_reg;
    logic [7:0] byte_reg;

    // The held byte leaves in the same cycle that a new one may come in.
    assign s_ready = !valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (fire) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_code_byte;
        end
    end

    assign q.valid     = valid_reg;
    assign q.code_byte = byte_reg;

endmodule

// ===== rtl/core/bid_decode.sv =====
// Instruction boundary decoder: holds the per-method state and the code length
// register, and works out one byte per firing. Depends on bid_pkg.
module bid_decode
    import bid_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  bid_in_t     in_q,
    input  logic        fire,
    output logic        res_valid,
    output bid_result_t res
);

    localparam int CW = (OFFSET_BITS + 2 > 17) ? OFFSET_BITS + 2 : 17;
    localparam int LW = (OFFSET_BITS + 1 > 16) ? OFFSET_BITS + 1 : 16;

    logic [15:0]            meth_len_reg;
    logic [OFFSET_BITS-1:0] offset_reg,  offset_next;
    logic [OFFSET_BITS-1:0] start_reg,   start_next;
    logic [16:0]            left_reg,    left_next;
    logic [7:0]             op_reg,      op_next;
    logic [2:0]             phase_reg,   phase_next;
    logic [31:0]            shift_reg,   shift_next;
    logic [31:0]            low_reg,     low_next;
    logic [15:0]            count_reg,   count_next;
    logic                   err_reg,     err_next;

    logic [7:0]             b;
    logic [OFFSET_BITS:0]   end_w;
    logic [CW-1:0]          pos_c, end_c, cl_c, start_c, sum4, pad_p, need, pad;
    logic                   done_end;
    logic [2:0]             flen, wlen;
    logic [31:0]            shift_new;
    logic [16:0]            left_dec, avail;
    logic signed [32:0]     diff;
    logic [14:0]            entries;
    logic                   fail_en, cmpl_en, rearm_en;
    logic [3:0]             fail_code;
    logic [15:0]            count_inc;
    logic [OFFSET_BITS-1:0] start_cur;
    logic [LW-1:0]          start_ext, len_ext;

    assign b        = in_q.code_byte;
    assign end_w    = {1'b0, offset_reg} + {{OFFSET_BITS{1'b0}}, 1'b1};
    assign pos_c    = CW'(offset_reg);
    assign end_c    = CW'(end_w);
    assign cl_c     = CW'(meth_len_reg);
    assign start_c  = CW'(start_reg);
    assign done_end = end_c >= cl_c;
    assign flen     = fixed_len(b);
    assign sum4     = pos_c + CW'(4);
    assign pad_p    = {sum4[CW-1:2], 2'b00};
    assign need     = pad_p + ((b == OP_TABLESWITCH) ? CW'(12) : CW'(8));
    assign pad      = pad_p - end_c;
    assign shift_new = {shift_reg[23:0], b};
    assign left_dec = left_reg - 17'd1;
    assign avail    = (cl_c > end_c) ? 17'(cl_c - end_c) : 17'd0;
    assign diff     = $signed({shift_new[31], shift_new}) - $signed({low_reg[31], low_reg});
    assign entries  = diff[14:0] + 15'd1;
    assign count_inc = count_reg + 16'd1;
    assign wlen     = (b == OP_IINC) ? 3'd6 : 3'd4;

    always_comb begin
        offset_next = offset_reg;
        start_next  = start_reg;
        left_next   = left_reg;
        op_next     = op_reg;
        phase_next  = phase_reg;
        shift_next  = shift_reg;
        low_next    = low_reg;
        count_next  = count_reg;
        err_next    = err_reg;
        fail_en     = 1'b0;
        fail_code   = ST_OK;
        cmpl_en     = 1'b0;
        rearm_en    = 1'b0;

        if (err_reg) begin
            // Bytes after an error are swallowed up to the end of the method.
            offset_next = end_w[OFFSET_BITS-1:0];
            rearm_en    = done_end;
        end else if (phase_reg == PH_IDLE) begin
            start_next  = offset_reg;
            op_next     = b;
            shift_next  = '0;
            offset_next = end_w[OFFSET_BITS-1:0];
            if (b == OP_WIDE) begin
                if (pos_c + CW'(2) > cl_c) begin
                    fail_en   = 1'b1;
                    fail_code = ST_TRUNC_WIDE;
                end else begin
                    phase_next = PH_WIDE;
                    left_next  = 17'd1;
                end
            end else if (b == OP_TABLESWITCH || b == OP_LOOKUPSWITCH) begin
                if (need > cl_c) begin
                    fail_en   = 1'b1;
                    fail_code = (b == OP_TABLESWITCH) ? ST_TRUNC_TSW : ST_TRUNC_LSW;
                end else begin
                    // Padding up to the word boundary, then the default field.
                    phase_next = PH_SKIP;
                    left_next  = {15'd0, pad[1:0]} + 17'd4;
                end
            end else if (pos_c + CW'(flen) > cl_c) begin
                fail_en   = 1'b1;
                fail_code = ST_OVERRUN;
            end else if (flen == 3'd1) begin
                cmpl_en = 1'b1;
            end else begin
                phase_next = PH_PLAIN;
                left_next  = 17'(flen - 3'd1);
            end
        end else begin
            shift_next  = shift_new;
            left_next   = left_dec;
            offset_next = end_w[OFFSET_BITS-1:0];
            if (phase_reg == PH_WIDE) begin
                if (b != OP_IINC && !is_wide_target(b)) begin
                    fail_en   = 1'b1;
                    fail_code = ST_BAD_WIDE_OP;
                end else if (start_c + CW'(wlen) > cl_c) begin
                    fail_en   = 1'b1;
                    fail_code = ST_OVERRUN;
                end else begin
                    phase_next = PH_PLAIN;
                    left_next  = 17'(wlen - 3'd2);
                end
            end else if (left_dec == 17'd0) begin
                unique case (phase_reg)
                    PH_SKIP: begin
                        phase_next = PH_FIELD1;
                        left_next  = 17'd4;
                        shift_next = '0;
                    end
                    PH_FIELD1: begin
                        if (op_reg == OP_TABLESWITCH) begin
                            low_next   = shift_new;
                            phase_next = PH_FIELD2;
                            left_next  = 17'd4;
                            shift_next = '0;
                        end else if (shift_new[31] ||
                                     shift_new > 32'(avail[16:3])) begin
                            fail_en   = 1'b1;
                            fail_code = ST_BAD_PAIRS;
                        end else if (shift_new == 32'd0) begin
                            cmpl_en = 1'b1;
                        end else begin
                            phase_next = PH_BODY;
                            left_next  = {shift_new[13:0], 3'b000};
                        end
                    end
                    PH_FIELD2: begin
                        if (diff[32]) begin
                            fail_en   = 1'b1;
                            fail_code = ST_BAD_BOUNDS;
                        end else if (diff[31:0] >= 32'(avail[16:2])) begin
                            // More entries than four-byte slots left in the method.
                            fail_en   = 1'b1;
                            fail_code = ST_TRUNC_ENTRY;
                        end else begin
                            phase_next = PH_BODY;
                            left_next  = {entries, 2'b00};
                        end
                    end
                    default: begin
                        cmpl_en = 1'b1;
                    end
                endcase
            end
        end

        if (fail_en) begin
            err_next   = 1'b1;
            phase_next = PH_IDLE;
            left_next  = '0;
            rearm_en   = done_end;
        end
        if (cmpl_en) begin
            count_next = count_inc;
            phase_next = PH_IDLE;
            left_next  = '0;
            rearm_en   = done_end;
        end
        // End of the method: everything but the method length returns to its reset value.
        if (rearm_en) begin
            offset_next = '0;
            start_next  = '0;
            left_next   = '0;
            op_next     = '0;
            phase_next  = PH_IDLE;
            shift_next  = '0;
            low_next    = '0;
            count_next  = '0;
            err_next    = 1'b0;
        end
    end

    // The start of the instruction being reported, taken before any end-of-method clear.
    assign start_cur = (phase_reg == PH_IDLE) ? offset_reg : start_reg;
    assign start_ext = LW'(start_cur);
    assign len_ext   = LW'(end_w) - LW'(start_cur);

    always_comb begin
        res_valid        = !err_reg && (fail_en || cmpl_en);
        res.start_offset = start_ext[15:0];
        res.instr_length = cmpl_en ? len_ext[15:0] : 16'd0;
        res.opcode_seen  = (phase_reg == PH_IDLE) ? b : op_reg;
        res.instr_count  = cmpl_en ? count_inc : count_reg;
        res.status       = fail_en ? fail_code : ST_OK;
        res.done_res     = fail_en || done_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meth_len_reg <= 16'd1;
        end else if (cfg_wr_en) begin
            meth_len_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
            start_reg  <= '0;
            left_reg   <= '0;
            op_reg     <= '0;
            phase_reg  <= PH_IDLE;
            shift_reg  <= '0;
            low_reg    <= '0;
            count_reg  <= '0;
            err_reg    <= 1'b0;
        end else if (fire) begin
            offset_reg <= offset_next;
            start_reg  <= start_next;
            left_reg   <= left_next;
            op_reg     <= op_next;
            phase_reg  <= phase_next;
            shift_reg  <= shift_next;
            low_reg    <= low_next;
            count_reg  <= count_next;
            err_reg    <= err_next;
        end
    end

endmodule

// ===== rtl/core/bid_out_stage.sv =====
// Result register of the bytecode instruction delimiter.
// Depends on bid_pkg.
module bid_out_stage
    import bid_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        fire,
    input  logic        res_valid,
    input  bid_result_t res,
    output logic        out_free,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_start_offset,
    output logic [15:0] m_instr_length,
    output logic [7:0]  m_opcode_seen,
    output logic [15:0] m_instr_count,
    output logic [3:0]  m_status,
    output logic        m_done_res
);

    logic        valid_reg;
    bid_result_t data_reg;

    // A new result may be loaded as the held one is taken.
    assign out_free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (fire && res_valid) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && res_valid) begin
            data_reg <= res;
        end
    end

    assign m_valid        = valid_reg;
    assign m_start_offset = data_reg.start_offset;
    assign m_instr_length = data_reg.instr_length;
    assign m_opcode_seen  = data_reg.opcode_seen;
    assign m_instr_count  = data_reg.instr_count;
    assign m_status       = data_reg.status;
    assign m_done_res     = data_reg.done_res;

endmodule

// ===== rtl/core/bytecode_instruction_delimiter_core.sv =====
// Bytecode instruction delimiter. Bytes of one method arrive one per transaction
// from offset zero; one result transaction is produced for every completed
// instruction (start, length, opcode, running count) and one for the first error,
// after which bytes are swallowed up to the end of the method. The block takes one
// byte every clock cycle while the result side keeps up: each byte passes the input
// register, one pass of decode logic and the result register, so a result is
// presented once its last byte has left the input register, and a result that waits
// holds the input for as long as it waits. The method length is written through
// cfg_wr_en/cfg_wr_data between methods; a method that reaches its length leaves
// the block ready for the next.
// Depends on bid_pkg, bid_in_stage, bid_decode and bid_out_stage.
module bytecode_instruction_delimiter_core
    import bid_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_code_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_start_offset,
    output logic [15:0] m_instr_length,
    output logic [7:0]  m_opcode_seen,
    output logic [15:0] m_instr_count,
    output logic [3:0]  m_status,
    output logic        m_done_res
);

    bid_in_t     in_q;
    bid_result_t res;
    logic        res_valid;
    logic        out_free;
    logic        fire;

    assign fire = in_q.valid && out_free;

    bid_in_stage u_in (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_code_byte (s_code_byte),
        .fire        (fire),
        .q           (in_q)
    );

    bid_decode #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_q        (in_q),
        .fire        (fire),
        .res_valid   (res_valid),
        .res         (res)
    );

    bid_out_stage u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .fire           (fire),
        .res_valid      (res_valid),
        .res            (res),
        .out_free       (out_free),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_start_offset (m_start_offset),
        .m_instr_length (m_instr_length),
        .m_opcode_seen  (m_opcode_seen),
        .m_instr_count  (m_instr_count),
        .m_status       (m_status),
        .m_done_res     (m_done_res)
    );

endmodule
